// ===== rtl/sphere_overlap_pushback_core_defines.svh =====
// Assertion macros used by the checker file sop_checker.sv.
`ifndef SPHERE_OVERLAP_PUSHBACK_CORE_DEFINES_SVH
`define SPHERE_OVERLAP_PUSHBACK_CORE_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define SOP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sop check failed");

// Next-cycle implication, held off during reset.
`define SOP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sop check failed");

`endif

// ===== rtl/sop_pkg.sv =====
`default_nettype none
package sop_pkg;

    typedef enum logic [1:0] {
        REG_OFFSET_X   = 2'd0,
        REG_OFFSET_Y   = 2'd1,
        REG_OFFSET_Z   = 2'd2,
        REG_OWN_RADIUS = 2'd3
    } t_cfg_reg;

    // sideband through the square-root pipe
    typedef struct packed {
        logic             hit;
        logic [2:0]       neg;
        logic [2:0][31:0] m;
        logic [31:0]      hr;
    } t_root_side;

    // sideband through the divider pipe
    typedef struct packed {
        logic       hit;
        logic       zero;
        logic [2:0] neg;
    } t_div_side;

endpackage
`default_nettype wire

// ===== rtl/sphere_overlap_pushback_core.sv =====
// Sphere-sphere overlap test with push-back vector, signed Q16.16.
// Input channel: i_valid / o_stall carries object position, other sphere
// centre and radius; a transfer happens when i_valid is high and o_stall low.
// Output channel: o_valid / i_stall carries hit and push_x/y/z, one result
// per input transfer, in order.
// Config: i_cfg_we writes i_cfg_data to register i_cfg_index (offset x/y/z,
// own radius); write only while the core is empty.
// Throughput: one item per cycle while no finished result is refused. Depth
// is set by the 32-stage square-root pipe and the 32-stage restoring
// divider, one result bit per stage each.
// The whole pipe advances as one; it holds only while o_valid is high and
// i_stall is high, and o_stall is raised in exactly those cycles. Bubbles
// move on freely, so an empty output slot never blocks input.
// Reset (synchronous, active low) clears all valid bits and the config
// registers to zero; no result is lost or repeated across a stall.
`default_nettype none
module sphere_overlap_pushback_core
    import sop_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // config
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    // input channel
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_self_x,
    input  wire logic signed [31:0] i_self_y,
    input  wire logic signed [31:0] i_self_z,
    input  wire logic signed [31:0] i_other_x,
    input  wire logic signed [31:0] i_other_y,
    input  wire logic signed [31:0] i_other_z,
    input  wire logic [30:0]        i_other_radius,
    // output channel
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_hit,
    output logic signed [31:0]      o_push_x,
    output logic signed [31:0]      o_push_y,
    output logic signed [31:0]      o_push_z
);

    logic en;

    // config registers
    logic [2:0][31:0] r_off;
    logic [30:0]      r_own_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off     <= '0;
            r_own_rad <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_OFFSET_X:   r_off[0]  <= i_cfg_data;
                REG_OFFSET_Y:   r_off[1]  <= i_cfg_data;
                REG_OFFSET_Z:   r_off[2]  <= i_cfg_data;
                REG_OWN_RADIUS: r_own_rad <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // global advance: hold only when a finished result is refused
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // ---- stage 1: difference vector and combined radius
    logic [2:0][31:0] w_self, w_other;
    logic             r1_v;
    logic [2:0][33:0] r1_d;
    logic [31:0]      r1_hr;

    assign w_self  = {i_self_z, i_self_y, i_self_x};
    assign w_other = {i_other_z, i_other_y, i_other_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                r1_d[l] <= {{2{w_other[l][31]}}, w_other[l]}
                         - ({{2{w_self[l][31]}}, w_self[l]}
                          + {{2{r_off[l][31]}}, r_off[l]});
            end
            r1_hr <= {1'b0, r_own_rad} + {1'b0, i_other_radius};
        end
    end

    // ---- stage 2: magnitudes, per-axis early reject
    logic [2:0][33:0] w_mag;
    logic             w_pre;
    logic             r2_v;
    logic             r2_pre;
    logic [2:0]       r2_neg;
    logic [2:0][31:0] r2_m;
    logic [31:0]      r2_hr;

    always_comb begin
        w_pre = 1'b1;
        for (int l = 0; l < 3; l++) begin
            w_mag[l] = r1_d[l][33] ? (34'd0 - r1_d[l]) : r1_d[l];
            if (w_mag[l] > {2'b00, r1_hr}) begin
                w_pre = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_pre <= w_pre;
            for (int l = 0; l < 3; l++) begin
                r2_neg[l] <= r1_d[l][33];
                r2_m[l]   <= w_mag[l][31:0]; // only used when it fits
            end
            r2_hr <= r1_hr;
        end
    end

    // ---- stage 3: squares
    logic             r3_v;
    logic             r3_pre;
    logic [2:0]       r3_neg;
    logic [2:0][31:0] r3_m;
    logic [2:0][63:0] r3_sq;
    logic [31:0]      r3_hr;
    logic [63:0]      r3_hr2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                r3_sq[l] <= 64'(r2_m[l]) * 64'(r2_m[l]);
            end
            r3_hr2 <= 64'(r2_hr) * 64'(r2_hr);
            r3_pre <= r2_pre;
            r3_neg <= r2_neg;
            r3_m   <= r2_m;
            r3_hr  <= r2_hr;
        end
    end

    // ---- stage 4: sum of squares and exact hit compare
    logic [65:0] w_sum;
    logic        r4_v;
    logic [63:0] r4_sum;
    t_root_side  r4_side;

    assign w_sum = {2'b00, r3_sq[0]} + {2'b00, r3_sq[1]} + {2'b00, r3_sq[2]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_sum       <= w_sum[63:0];
            r4_side.hit  <= r3_pre && (w_sum <= {2'b00, r3_hr2});
            r4_side.neg  <= r3_neg;
            r4_side.m    <= r3_m;
            r4_side.hr   <= r3_hr;
        end
    end

    // ---- |d| = floor(sqrt(sum)), Q16.16 directly
    logic        rt_v;
    logic [31:0] rt_root;
    t_root_side  rt_side;

    sop_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (r4_v),
        .i_rad   (r4_sum),
        .i_side  (r4_side),
        .o_v     (rt_v),
        .o_root  (rt_root),
        .o_side  (rt_side)
    );

    // ---- penetration depth (root <= hr on a hit)
    logic             r5_v;
    logic [31:0]      r5_pen;
    logic [31:0]      r5_dist;
    logic [2:0][31:0] r5_m;
    t_div_side        r5_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= rt_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_pen       <= rt_side.hr - rt_root;
            r5_dist      <= rt_root;
            r5_m         <= rt_side.m;
            r5_side.hit  <= rt_side.hit;
            r5_side.zero <= rt_root == 32'd0;
            r5_side.neg  <= rt_side.neg;
        end
    end

    // ---- numerators |d_i| * pen
    logic             r6_v;
    logic [2:0][63:0] r6_prod;
    logic [31:0]      r6_dist;
    t_div_side        r6_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                r6_prod[l] <= 64'(r5_m[l]) * 64'(r5_pen);
            end
            r6_dist <= r5_dist;
            r6_side <= r5_side;
        end
    end

    // ---- divide by |d|
    logic             dv_v;
    logic [2:0][31:0] dv_q;
    logic [2:0]       dv_ovf;
    t_div_side        dv_side;

    sop_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (r6_v),
        .i_prod  (r6_prod),
        .i_dist  (r6_dist),
        .i_side  (r6_side),
        .o_v     (dv_v),
        .o_q     (dv_q),
        .o_ovf   (dv_ovf),
        .o_side  (dv_side)
    );

    // ---- sign, saturate, output register
    logic [2:0][31:0] w_push;
    logic [2:0][31:0] r_push;
    logic             r_hit;
    logic             r_out_v;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (!dv_side.hit || dv_side.zero) begin
                w_push[l] = '0;
            end else if (dv_ovf[l] || dv_q[l][31]) begin
                w_push[l] = dv_side.neg[l] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                w_push[l] = dv_side.neg[l] ? (32'd0 - dv_q[l]) : dv_q[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_push <= w_push;
            r_hit  <= dv_side.hit;
        end
    end

    assign o_valid  = r_out_v;
    assign o_hit    = r_hit;
    assign o_push_x = r_push[0];
    assign o_push_y = r_push[1];
    assign o_push_z = r_push[2];

endmodule
`default_nettype wire

// ===== rtl/sop_isqrt.sv =====
`default_nettype none
module sop_isqrt
    import sop_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_v,
    input  wire logic [63:0] i_rad,
    input  wire t_root_side  i_side,
    output logic             o_v,
    output logic [31:0]      o_root,
    output t_root_side       o_side
);

    // one root bit per stage, MSB first
    logic        s_v    [0:32];
    logic [63:0] s_rem  [0:32];
    logic [31:0] s_root [0:32];
    t_root_side  s_side [0:32];

    assign s_v[0]    = i_v;
    assign s_rem[0]  = i_rad;
    assign s_root[0] = '0;
    assign s_side[0] = i_side;

    for (genvar g = 0; g < 32; g++) begin : g_stage
        localparam int BitI = 31 - g;
        logic [65:0] w_trial;
        logic        w_take;
        logic        r_v;
        logic [63:0] r_rem;
        logic [31:0] r_root;
        t_root_side  r_side;

        assign w_trial = ({34'd0, s_root[g]} << (BitI + 1)) + (66'd1 << (2 * BitI));
        assign w_take  = {2'b00, s_rem[g]} >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= s_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= w_take ? (s_rem[g] - w_trial[63:0]) : s_rem[g];
                r_root <= w_take ? (s_root[g] | (32'd1 << BitI)) : s_root[g];
                r_side <= s_side[g];
            end
        end

        assign s_v[g+1]    = r_v;
        assign s_rem[g+1]  = r_rem;
        assign s_root[g+1] = r_root;
        assign s_side[g+1] = r_side;
    end

    assign o_v    = s_v[32];
    assign o_root = s_root[32];
    assign o_side = s_side[32];

endmodule
`default_nettype wire

// ===== rtl/sop_div.sv =====
`default_nettype none
module sop_div
    import sop_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_v,
    input  wire logic [2:0][63:0] i_prod,
    input  wire logic [31:0]      i_dist,
    input  wire t_div_side        i_side,
    output logic                  o_v,
    output logic [2:0][31:0]      o_q,
    output logic [2:0]            o_ovf,
    output t_div_side             o_side
);

    // restoring divide, three lanes, one quotient bit per stage
    logic             s_v    [0:32];
    logic [2:0][31:0] s_rem  [0:32];
    logic [2:0][31:0] s_lo   [0:32];
    logic [2:0][31:0] s_q    [0:32];
    logic [2:0]       s_ovf  [0:32];
    logic [31:0]      s_dist [0:32];
    t_div_side        s_side [0:32];

    logic             r_v0;
    logic [2:0][31:0] r_rem0;
    logic [2:0][31:0] r_lo0;
    logic [2:0]       r_ovf0;
    logic [31:0]      r_dist0;
    t_div_side        r_side0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                r_rem0[l] <= i_prod[l][63:32];
                r_lo0[l]  <= i_prod[l][31:0];
                r_ovf0[l] <= i_prod[l][63:32] >= i_dist; // quotient needs > 32 bits
            end
            r_dist0 <= i_dist;
            r_side0 <= i_side;
        end
    end

    assign s_v[0]    = r_v0;
    assign s_rem[0]  = r_rem0;
    assign s_lo[0]   = r_lo0;
    assign s_q[0]    = '0;
    assign s_ovf[0]  = r_ovf0;
    assign s_dist[0] = r_dist0;
    assign s_side[0] = r_side0;

    for (genvar g = 0; g < 32; g++) begin : g_stage
        logic             r_v;
        logic [2:0][31:0] r_rem;
        logic [2:0][31:0] r_lo;
        logic [2:0][31:0] r_q;
        logic [2:0]       r_ovf;
        logic [31:0]      r_dist;
        t_div_side        r_side;
        logic [2:0][32:0] w_t;
        logic [2:0][32:0] w_diff;
        logic [2:0]       w_take;

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                w_t[l]    = {s_rem[g][l], s_lo[g][l][31]};
                w_diff[l] = w_t[l] - {1'b0, s_dist[g]};
                w_take[l] = w_t[l] >= {1'b0, s_dist[g]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= s_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < 3; l++) begin
                    r_rem[l] <= w_take[l] ? w_diff[l][31:0] : w_t[l][31:0];
                    r_lo[l]  <= {s_lo[g][l][30:0], 1'b0};
                    r_q[l]   <= {s_q[g][l][30:0], w_take[l]};
                end
                r_ovf  <= s_ovf[g];
                r_dist <= s_dist[g];
                r_side <= s_side[g];
            end
        end

        assign s_v[g+1]    = r_v;
        assign s_rem[g+1]  = r_rem;
        assign s_lo[g+1]   = r_lo;
        assign s_q[g+1]    = r_q;
        assign s_ovf[g+1]  = r_ovf;
        assign s_dist[g+1] = r_dist;
        assign s_side[g+1] = r_side;
    end

    assign o_v    = s_v[32];
    assign o_q    = s_q[32];
    assign o_ovf  = s_ovf[32];
    assign o_side = s_side[32];

endmodule
`default_nettype wire

// ===== rtl/sop_checker.sv =====
`default_nettype none
`include "sphere_overlap_pushback_core_defines.svh"
module sop_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_cfg_we,
    input wire logic [1:0]         i_cfg_index,
    input wire logic [31:0]        i_cfg_data,
    input wire logic               i_valid,
    input wire logic               o_stall,
    input wire logic signed [31:0] i_self_x,
    input wire logic signed [31:0] i_self_y,
    input wire logic signed [31:0] i_self_z,
    input wire logic signed [31:0] i_other_x,
    input wire logic signed [31:0] i_other_y,
    input wire logic signed [31:0] i_other_z,
    input wire logic [30:0]        i_other_radius,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire logic               o_hit,
    input wire logic signed [31:0] o_push_x,
    input wire logic signed [31:0] o_push_y,
    input wire logic signed [31:0] o_push_z
);

    // a miss never carries a push
    `SOP_ASSERT_NOW(a_miss_no_push, i_clk, i_rst_n, o_valid && !o_hit,
        o_push_x == 32'sd0 && o_push_y == 32'sd0 && o_push_z == 32'sd0)

    // input is held off only by a refused result
    `SOP_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)

    // refused result stays put
    `SOP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_hit) && $stable(o_push_x) && $stable(o_push_y)
        && $stable(o_push_z))

endmodule

bind sphere_overlap_pushback_core sop_checker u_sop_checker (.*);
`default_nettype wire
